>>> hdl/atm_pkg.sv
package atm_pkg;

   // Build defaults
   localparam int DEF_MAX_RADIUS   = 3;
   localparam int DEF_MAX_WIDTH    = 2048;
   localparam int DEF_MAX_CHANNELS = 4;

   // Fixed field and register widths
   localparam int SAMPLE_W   = 8;
   localparam int ROW_W      = 12;
   localparam int HEIGHT_W   = 13;
   localparam int HEIGHT_MAX = 4096;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRIM     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 3'd4;

   // Register reset values
   localparam logic [1:0]  RST_RADIUS   = 2'd1;
   localparam logic [4:0]  RST_TRIM     = 5'd0;
   localparam logic [11:0] RST_WIDTH    = 12'd640;
   localparam logic [12:0] RST_HEIGHT   = 13'd480;
   localparam logic [2:0]  RST_CHANNELS = 3'd1;

   // Item codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   typedef struct packed {
      logic accept;
      logic win_init;
      logic win_slot;
      logic read;
      logic insert;
      logic sum;
      logic div_init;
      logic div_step;
      logic finish;
   } atm_cmd_type;

   typedef struct packed {
      logic out_ready;
      logic win_last;
      logic sum_last;
      logic div_last;
      logic rsp_busy;
   } atm_status_type;

endpackage

>>> hdl/atm_controller.sv
module atm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  atm_pkg::atm_status_type status,
   output atm_pkg::atm_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_RQ    = 4'd2;
   localparam logic [3:0] S_RS    = 4'd3;
   localparam logic [3:0] S_RD    = 4'd4;
   localparam logic [3:0] S_INS   = 4'd5;
   localparam logic [3:0] S_SUM   = 4'd6;
   localparam logic [3:0] S_DIVI  = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: state_in = status.out_ready ? S_RQ : S_IDLE;
         S_RQ: begin
            cmd.win_init = 1'b1;
            state_in     = S_RS;
         end
         S_RS: begin
            cmd.win_slot = 1'b1;
            state_in     = S_RD;
         end
         S_RD: begin
            cmd.read = 1'b1;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.insert = 1'b1;
            state_in   = status.win_last ? S_SUM : S_RD;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = status.sum_last ? S_DIVI : S_SUM;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = status.div_last ? S_FIN : S_DIV;
         end
         S_FIN: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/atm_datapath.sv
module atm_datapath #(
   parameter int MAX_RADIUS   = atm_pkg::DEF_MAX_RADIUS,
   parameter int MAX_WIDTH    = atm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = atm_pkg::DEF_MAX_CHANNELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [atm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [atm_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_cmd,
   input  logic [atm_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [atm_pkg::SAMPLE_W-1:0]      rsp_filtered,
   output logic                              rsp_frame_end,
   input  atm_pkg::atm_cmd_type              cmd,
   output atm_pkg::atm_status_type           status
);

   localparam int SLOTS   = 2 * MAX_RADIUS + 1;
   localparam int WMAX    = SLOTS * SLOTS;
   localparam int DEPTH   = SLOTS * MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int OFF_W   = RAD_W + 1;
   localparam int CNT_W   = $clog2(WMAX + 1);
   localparam int SUM_W   = $clog2(WMAX * 255 + 1);
   localparam int DCNT_W  = $clog2(SUM_W);
   localparam int ROW_W   = atm_pkg::ROW_W;
   localparam int RECIP   = (2 ** ROW_W) / SLOTS;
   localparam int SW      = atm_pkg::SAMPLE_W;

   function automatic int clamp_coord(int v, int lim);
      int res;
      res = v;
      if (v < 0) res = 0;
      else if (v > lim - 1) res = lim - 1;
      return res;
   endfunction

   // configuration
   logic [1:0]  radius_ff;
   logic [4:0]  trim_ff;
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [2:0]  chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= atm_pkg::RST_RADIUS;
         trim_ff   <= atm_pkg::RST_TRIM;
         width_ff  <= atm_pkg::RST_WIDTH;
         height_ff <= atm_pkg::RST_HEIGHT;
         chans_ff  <= atm_pkg::RST_CHANNELS;
      end else if (csr_we) begin
         unique case (csr_index)
            atm_pkg::REG_RADIUS:   radius_ff <= csr_data[1:0];
            atm_pkg::REG_TRIM:     trim_ff   <= csr_data[4:0];
            atm_pkg::REG_WIDTH:    width_ff  <= csr_data[11:0];
            atm_pkg::REG_HEIGHT:   height_ff <= csr_data[12:0];
            atm_pkg::REG_CHANNELS: chans_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   logic [RAD_W-1:0]  eff_r;
   logic [WCNT_W-1:0] eff_w;
   logic [12:0]       eff_h;
   logic [2:0]        eff_c;

   always_comb begin
      eff_r = (int'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_ff);
      if (width_ff == '0) eff_w = WCNT_W'(1);
      else if (int'(width_ff) > MAX_WIDTH) eff_w = WCNT_W'(MAX_WIDTH);
      else eff_w = WCNT_W'(width_ff);
      if (height_ff == '0) eff_h = 13'd1;
      else if (int'(height_ff) > atm_pkg::HEIGHT_MAX) eff_h = 13'(atm_pkg::HEIGHT_MAX);
      else eff_h = height_ff;
      if (chans_ff == '0) eff_c = 3'd1;
      else if (int'(chans_ff) > MAX_CHANNELS) eff_c = 3'(MAX_CHANNELS);
      else eff_c = chans_ff;
   end

   // raster positions
   logic [ROW_W-1:0]  in_row_ff, out_row_ff, in_row_nx, out_row_nx;
   logic [COL_W-1:0]  in_col_ff, out_col_ff, in_col_nx, out_col_nx;
   logic [CH_W-1:0]   in_chan_ff, out_chan_ff, in_chan_nx, out_chan_nx;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_nx;
   logic              in_wrap, out_wrap, ahead_ff;

   always_comb begin
      in_row_nx  = in_row_ff;
      in_col_nx  = in_col_ff;
      in_chan_nx = in_chan_ff;
      in_slot_nx = in_slot_ff;
      in_wrap    = 1'b0;
      if (int'(in_chan_ff) + 1 < int'(eff_c)) begin
         in_chan_nx = in_chan_ff + 1'b1;
      end else begin
         in_chan_nx = '0;
         if (int'(in_col_ff) + 1 < int'(eff_w)) begin
            in_col_nx = in_col_ff + 1'b1;
         end else begin
            in_col_nx = '0;
            if (int'(in_row_ff) + 1 < int'(eff_h)) begin
               in_row_nx  = in_row_ff + 1'b1;
               in_slot_nx = (int'(in_slot_ff) == SLOTS - 1) ? '0 : in_slot_ff + 1'b1;
            end else begin
               in_row_nx  = '0;
               in_slot_nx = '0;
               in_wrap    = 1'b1;
            end
         end
      end
   end

   always_comb begin
      out_row_nx  = out_row_ff;
      out_col_nx  = out_col_ff;
      out_chan_nx = out_chan_ff;
      out_wrap    = 1'b0;
      if (int'(out_chan_ff) + 1 < int'(eff_c)) begin
         out_chan_nx = out_chan_ff + 1'b1;
      end else begin
         out_chan_nx = '0;
         if (int'(out_col_ff) + 1 < int'(eff_w)) begin
            out_col_nx = out_col_ff + 1'b1;
         end else begin
            out_col_nx = '0;
            if (int'(out_row_ff) + 1 < int'(eff_h)) begin
               out_row_nx = out_row_ff + 1'b1;
            end else begin
               out_row_nx = '0;
               out_wrap   = 1'b1;
            end
         end
      end
   end

   // window readiness: input has passed the last sample this window needs
   always_comb begin
      int rr, cc;
      rr = int'(out_row_ff) + int'(eff_r);
      if (rr > int'(eff_h) - 1) rr = int'(eff_h) - 1;
      cc = int'(out_col_ff) + int'(eff_r);
      if (cc > int'(eff_w) - 1) cc = int'(eff_w) - 1;
      if (ahead_ff) status.out_ready = 1'b1;
      else if (int'(in_row_ff) != rr) status.out_ready = int'(in_row_ff) > rr;
      else if (int'(in_col_ff) != cc) status.out_ready = int'(in_col_ff) > cc;
      else status.out_ready = in_chan_ff > out_chan_ff;
   end

   // window walk
   logic signed [OFF_W-1:0] di_ff, dj_ff, r_s;
   logic [ROW_W-1:0]        y_ff, y0, ny;
   logic [ROW_W-1:0]        q_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [COL_W-1:0]        x;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [SW-1:0]           rd_data_ff;
   logic [SW-1:0]           line_mem [DEPTH];

   assign r_s = $signed({1'b0, eff_r});
   assign y0  = ROW_W'(clamp_coord(int'(out_row_ff) - int'(eff_r), int'(eff_h)));
   assign ny  = ROW_W'(clamp_coord(int'(out_row_ff) + int'(di_ff) + 1, int'(eff_h)));
   assign x   = COL_W'(clamp_coord(int'(out_col_ff) + int'(dj_ff), int'(eff_w)));

   assign wr_addr = ADDR_W'(int'(in_slot_ff) * (MAX_WIDTH * MAX_CHANNELS)
                            + int'(in_col_ff) * MAX_CHANNELS + int'(in_chan_ff));
   assign rd_addr = ADDR_W'(int'(slot_ff) * (MAX_WIDTH * MAX_CHANNELS)
                            + int'(x) * MAX_CHANNELS + int'(out_chan_ff));

   always_ff @(posedge clock) begin
      if (cmd.accept && req_cmd == atm_pkg::CMD_SAMPLE) begin
         line_mem[wr_addr] <= req_sample;
      end
      if (cmd.read) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign status.win_last = (dj_ff == r_s) && (di_ff == r_s);

   // sorted list, insertion by parallel compare and shift
   logic [SW-1:0]    vals_ff [WMAX];
   logic [SW-1:0]    vals_ins [WMAX];
   logic [WMAX-1:0]  gt;
   logic [CNT_W-1:0] n_ff, k_ff, a_ff, den_ff;

   always_comb begin
      for (int p = 0; p < WMAX; p++) begin
         gt[p] = (p < int'(n_ff)) && (vals_ff[p] > rd_data_ff);
      end
      for (int p = 0; p < WMAX; p++) begin
         vals_ins[p] = vals_ff[p];
         if (p <= int'(n_ff)) begin
            if (p > 0 && gt[p > 0 ? p - 1 : 0]) vals_ins[p] = vals_ff[p > 0 ? p - 1 : 0];
            else if (gt[p] || p == int'(n_ff)) vals_ins[p] = rd_data_ff;
         end
      end
   end

   logic [SUM_W-1:0] acc_ff;
   assign status.sum_last = (k_ff == CNT_W'(int'(n_ff) - 1));

   // restoring divider
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W:0]    rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [CNT_W+1:0]  trial;

   assign trial = {rem_ff, quo_ff[SUM_W-1]} - {2'b00, den_ff};
   assign status.div_last = (dcnt_ff == DCNT_W'(SUM_W - 1));

   always_ff @(posedge clock) begin
      int rem, half, a, ntot;
      rem  = int'(y_ff) - int'(q_ff) * SLOTS;
      if (rem >= SLOTS) rem = rem - SLOTS;
      half = 2 * int'(eff_r) * (int'(eff_r) + 1);
      a    = (int'(trim_ff) > half) ? half : int'(trim_ff);
      ntot = (2 * int'(eff_r) + 1) * (2 * int'(eff_r) + 1);
      if (cmd.win_init) begin
         y_ff  <= y0;
         q_ff  <= ROW_W'((2 * ROW_W)'(y0) * (2 * ROW_W)'(RECIP) >> ROW_W);
         di_ff <= -r_s;
         dj_ff <= -r_s;
         n_ff  <= '0;
         k_ff  <= '0;
         acc_ff <= '0;
      end
      if (cmd.win_slot) begin
         slot_ff <= SLOT_W'(rem);
         a_ff    <= CNT_W'(a);
         den_ff  <= CNT_W'(ntot - 2 * a);
      end
      if (cmd.insert) begin
         for (int p = 0; p < WMAX; p++) vals_ff[p] <= vals_ins[p];
         n_ff <= n_ff + 1'b1;
         if (dj_ff == r_s) begin
            dj_ff <= -r_s;
            di_ff <= di_ff + 1'b1;
            // advance the row slot only when the clamped row moves
            if (ny != y_ff) begin
               y_ff    <= y_ff + 1'b1;
               slot_ff <= (int'(slot_ff) == SLOTS - 1) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            dj_ff <= dj_ff + 1'b1;
         end
      end
      if (cmd.sum) begin
         if (k_ff >= a_ff && int'(k_ff) < int'(n_ff) - int'(a_ff)) begin
            acc_ff <= acc_ff + SUM_W'(vals_ff[0]);
         end
         for (int p = 0; p < WMAX - 1; p++) vals_ff[p] <= vals_ff[p + 1];
         vals_ff[WMAX-1] <= '0;
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.div_init) begin
         quo_ff  <= acc_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[CNT_W+1]) begin
            rem_ff <= trial[CNT_W:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   // positions, pending-image flag and output register
   logic          rsp_valid_ff, rsp_frame_end_ff;
   logic [SW-1:0] rsp_filtered_ff;

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered    = rsp_filtered_ff;
   assign rsp_frame_end   = rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_chan_ff   <= '0;
         in_slot_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_chan_ff  <= '0;
         ahead_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_cmd == atm_pkg::CMD_SAMPLE) begin
            in_row_ff  <= in_row_nx;
            in_col_ff  <= in_col_nx;
            in_chan_ff <= in_chan_nx;
            in_slot_ff <= in_slot_nx;
            if (in_wrap) ahead_ff <= 1'b1;
         end
         if (cmd.finish) begin
            out_row_ff   <= out_row_nx;
            out_col_ff   <= out_col_nx;
            out_chan_ff  <= out_chan_nx;
            if (out_wrap) ahead_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_filtered_ff  <= (quo_ff > SUM_W'(255)) ? 8'hFF : quo_ff[SW-1:0];
         rsp_frame_end_ff <= out_wrap;
      end
   end

endmodule

>>> hdl/alpha_trimmed_mean_window_filter.sv
// Timing: an item that completes no window only passes the readiness check; one
// that does also runs the (2r+1)^2 window reads, the trim sum and the divider steps.
// Throughput: one item at a time; the window walk (a line-store read and then a
// sorted insertion per sample), the trim sum and the bit-serial divide set it.
// Reset: synchronous, active high; loads the configuration defaults and clears
// positions and the output valid. The line store is not cleared.
module alpha_trimmed_mean_window_filter #(
   parameter int MAX_RADIUS   = atm_pkg::DEF_MAX_RADIUS,
   parameter int MAX_WIDTH    = atm_pkg::DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = atm_pkg::DEF_MAX_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [atm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [atm_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [atm_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [atm_pkg::SAMPLE_W-1:0]    rsp_filtered,
   output logic                            rsp_frame_end
);

   atm_pkg::atm_cmd_type    cmd;
   atm_pkg::atm_status_type status;

   atm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   atm_datapath #(
      .MAX_RADIUS   (MAX_RADIUS),
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_cmd       (req_cmd),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_frame_end (rsp_frame_end),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

>>> test/atm_checker.sv
module atm_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [atm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atm_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [atm_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [atm_pkg::SAMPLE_W-1:0]   rsp_filtered,
   input  logic                           rsp_frame_end,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 2 * atm_pkg::DEF_MAX_RADIUS + 1;
   localparam int STORE_DEPTH = SLOTS * atm_pkg::DEF_MAX_WIDTH * atm_pkg::DEF_MAX_CHANNELS;
   localparam int WIN_MAX     = SLOTS * SLOTS;

   typedef struct packed {
      logic [atm_pkg::SAMPLE_W-1:0] filtered;
      logic                         frame_end;
   } pixel_result_type;

   logic [1:0]  radius;
   logic [4:0]  trim;
   logic [11:0] img_w;
   logic [12:0] img_h;
   logic [2:0]  chans;

   bit [atm_pkg::SAMPLE_W-1:0] line_store [STORE_DEPTH];
   int unsigned in_row, in_col, in_chan, out_row, out_col, out_chan;
   bit ahead;
   pixel_result_type expected_q [$];

   function automatic int unsigned eff_radius();
      return (radius > atm_pkg::DEF_MAX_RADIUS) ? atm_pkg::DEF_MAX_RADIUS : radius;
   endfunction

   function automatic int unsigned eff_width();
      if (img_w == 0) return 1;
      return (img_w > atm_pkg::DEF_MAX_WIDTH) ? atm_pkg::DEF_MAX_WIDTH : img_w;
   endfunction

   function automatic int unsigned eff_height();
      if (img_h == 0) return 1;
      return (img_h > atm_pkg::HEIGHT_MAX) ? atm_pkg::HEIGHT_MAX : img_h;
   endfunction

   function automatic int unsigned eff_chans();
      if (chans == 0) return 1;
      return (chans > atm_pkg::DEF_MAX_CHANNELS) ? atm_pkg::DEF_MAX_CHANNELS : chans;
   endfunction

   function automatic int unsigned store_index(int unsigned row, int unsigned col,
                                               int unsigned chan);
      if (col >= atm_pkg::DEF_MAX_WIDTH) col = atm_pkg::DEF_MAX_WIDTH - 1;
      if (chan >= atm_pkg::DEF_MAX_CHANNELS) chan = atm_pkg::DEF_MAX_CHANNELS - 1;
      return ((row % SLOTS) * atm_pkg::DEF_MAX_WIDTH + col) * atm_pkg::DEF_MAX_CHANNELS
             + chan;
   endfunction

   // step a raster position; true when it wraps past the end of the image
   function automatic bit advance_pos(inout int unsigned row, inout int unsigned col,
                                      inout int unsigned chan);
      if (chan + 1 < eff_chans()) begin
         chan++;
         return 0;
      end
      chan = 0;
      if (col + 1 < eff_width()) begin
         col++;
         return 0;
      end
      col = 0;
      if (row + 1 < eff_height()) begin
         row++;
         return 0;
      end
      row = 0;
      return 1;
   endfunction

   function automatic bit window_ready();
      int unsigned rr, cc;
      if (ahead) return 1;
      rr = out_row + eff_radius();
      if (rr > eff_height() - 1) rr = eff_height() - 1;
      cc = out_col + eff_radius();
      if (cc > eff_width() - 1) cc = eff_width() - 1;
      if (in_row != rr) return in_row > rr;
      if (in_col != cc) return in_col > cc;
      return in_chan > out_chan;
   endfunction

   function automatic logic [atm_pkg::SAMPLE_W-1:0] trimmed_mean();
      int unsigned vals [WIN_MAX];
      int r, i, j, yy, xx;
      int unsigned n, a, k, sum, q, v, p, y, x;
      r = eff_radius();
      n = 0;
      sum = 0;
      for (i = -r; i <= r; i++) begin
         yy = int'(out_row) + i;
         y = (yy < 0) ? 0 : ((yy > int'(eff_height()) - 1) ? eff_height() - 1 : yy);
         for (j = -r; j <= r; j++) begin
            xx = int'(out_col) + j;
            x = (xx < 0) ? 0 : ((xx > int'(eff_width()) - 1) ? eff_width() - 1 : xx);
            v = line_store[store_index(y, x, out_chan)];
            // insertion keeps the window sorted
            p = n;
            while (p > 0 && vals[p-1] > v) begin
               vals[p] = vals[p-1];
               p--;
            end
            vals[p] = v;
            n++;
         end
      end
      a = trim;
      if (a > (n - 1) / 2) a = (n - 1) / 2;
      for (k = a; k < n - a; k++) sum += vals[k];
      q = sum / (n - 2 * a);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   always @(posedge clock) begin
      pixel_result_type got, want;
      bit last;
      if (reset) begin
         radius = atm_pkg::RST_RADIUS;
         trim = atm_pkg::RST_TRIM;
         img_w = atm_pkg::RST_WIDTH;
         img_h = atm_pkg::RST_HEIGHT;
         chans = atm_pkg::RST_CHANNELS;
         in_row = 0; in_col = 0; in_chan = 0;
         out_row = 0; out_col = 0; out_chan = 0;
         ahead = 0;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               atm_pkg::REG_RADIUS:   radius = csr_data[1:0];
               atm_pkg::REG_TRIM:     trim = csr_data[4:0];
               atm_pkg::REG_WIDTH:    img_w = csr_data[11:0];
               atm_pkg::REG_HEIGHT:   img_h = csr_data[12:0];
               atm_pkg::REG_CHANNELS: chans = csr_data[2:0];
               default: ;
            endcase
         end
         // compare before queueing, so a result never meets its own item
         if (rsp_valid && rsp_ready) begin
            got.filtered = rsp_filtered;
            got.frame_end = rsp_frame_end;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: filtered=%0d frame_end=%0b",
                           got.filtered, got.frame_end);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected filtered=%0d frame_end=%0b, ",
                               "got filtered=%0d frame_end=%0b"},
                              want.filtered, want.frame_end, got.filtered, got.frame_end);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == atm_pkg::CMD_SAMPLE) begin
               line_store[store_index(in_row, in_col, in_chan)] = req_sample;
               if (advance_pos(in_row, in_col, in_chan)) ahead = 1;
            end
            if (window_ready()) begin
               want.filtered = trimmed_mean();
               last = advance_pos(out_row, out_col, out_chan);
               if (last) ahead = 0;
               want.frame_end = last;
               expected_q.insert(expected_q.size(), want);
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

>>> test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [atm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [atm_pkg::CSR_DATA_W-1:0] csr_data;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_cmd;
   logic [atm_pkg::SAMPLE_W-1:0]   req_sample;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [atm_pkg::SAMPLE_W-1:0]   rsp_filtered;
   logic                           rsp_frame_end;

   int fail_count;
   int pending;
   int frames_sent = 0;
   int frames_seen = 0;
   int random_items = 0;
   bit calm = 0;

   alpha_trimmed_mean_window_filter DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_filtered(rsp_filtered), .rsp_frame_end(rsp_frame_end)
   );

   atm_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_filtered(rsp_filtered), .rsp_frame_end(rsp_frame_end),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= 14);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_frame_end) frames_seen <= frames_seen + 1;

   initial begin
      #100ms;
      $display("FAIL");
      $finish;
   end

   task automatic write_reg(logic [atm_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value[atm_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(logic cmd, logic [atm_pkg::SAMPLE_W-1:0] value);
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the input until every outstanding result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic flush_to(int target);
      while (frames_seen < target) send(atm_pkg::CMD_FLUSH, atm_pkg::SAMPLE_W'($urandom));
   endtask

   function automatic logic [atm_pkg::SAMPLE_W-1:0] pick_sample();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return atm_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(int r, int t, int w, int h, int ch, int images, bit overlap,
                            int pause_at, output int items);
      int ew, eh, ec, img, k;
      ew = (w == 0) ? 1 : ((w > atm_pkg::DEF_MAX_WIDTH) ? atm_pkg::DEF_MAX_WIDTH : w);
      eh = (h == 0) ? 1 : ((h > atm_pkg::HEIGHT_MAX) ? atm_pkg::HEIGHT_MAX : h);
      ec = (ch == 0) ? 1 : ((ch > atm_pkg::DEF_MAX_CHANNELS) ? atm_pkg::DEF_MAX_CHANNELS : ch);
      write_reg(atm_pkg::REG_RADIUS, r);
      write_reg(atm_pkg::REG_TRIM, t);
      write_reg(atm_pkg::REG_WIDTH, w);
      write_reg(atm_pkg::REG_HEIGHT, h);
      write_reg(atm_pkg::REG_CHANNELS, ch);
      if ($urandom_range(0, 7) == 0)
         write_reg(atm_pkg::REG_CHANNELS + 3'($urandom_range(1, 3)), $urandom);
      // flush with nothing to emit yet
      if ($urandom_range(0, 3) == 0) send(atm_pkg::CMD_FLUSH, atm_pkg::SAMPLE_W'($urandom));
      items = 0;
      for (img = 0; img < images; img++) begin
         for (k = 0; k < ew * eh * ec; k++) begin
            if (img == 0 && k == pause_at) drain();
            send(atm_pkg::CMD_SAMPLE, pick_sample());
            items++;
         end
         frames_sent++;
         if (!overlap) flush_to(frames_sent);
      end
      flush_to(frames_sent);
      drain();
   endtask

   initial begin
      int n, w, h, ch;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = atm_pkg::REG_RADIUS;
      csr_data = '0;
      req_valid = 1'b0;
      req_cmd = atm_pkg::CMD_SAMPLE;
      req_sample = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      run_phase(3, 24, 5, 4, 1, 1, 0, -1, n);
      run_phase(1, 31, 3, 3, 4, 1, 0, 5, n);
      run_phase(0, 0, 1, 1, 1, 2, 1, -1, n);
      run_phase(2, 3, 0, 0, 0, 1, 0, -1, n);
      run_phase(3, 5, 2, 6, 7, 2, 1, -1, n);

      // long stretch with no idling on either side
      calm = 1;
      run_phase(1, 2, 12, 8, 1, 1, 0, -1, n);
      calm = 0;

      while (random_items < 650) begin
         w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
         h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
         ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
         calm = ($urandom_range(0, 5) == 0);
         run_phase($urandom_range(0, 3), $urandom_range(0, 31), w, h, ch,
                   $urandom_range(1, 3), $urandom_range(0, 1),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : -1, n);
         random_items += n;
      end
      calm = 0;

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
